// ===== rtl/core/ucng_pkg.sv =====
// Shared constants, types and a helper function of the UTF-8 character n-gram splitter.
`timescale 1ns / 1ps

package ucng_pkg;

    // Deepest gram, and so the depth of the ring of character starts.
    localparam int MAX_GRAM_CHARS = 32;
    localparam int RING_AW        = $clog2(MAX_GRAM_CHARS);

    // Byte positions saturate here; the position counter can hold the cap itself.
    localparam int POS_CAP = 65536;
    localparam int POS_W   = $clog2(POS_CAP) + 1;

    // Field widths of the channels.
    localparam int CFG_W    = 6;
    localparam int OFF_W    = 16;
    localparam int LEN_W    = 8;
    localparam int IDX_W    = 16;
    localparam int CHARS_W  = 17;
    localparam int LEFT_W   = 2;

    localparam logic [CHARS_W-1:0] CHARS_MAX = {CHARS_W{1'b1}};
    localparam logic [IDX_W-1:0]   GRAMS_MAX = {IDX_W{1'b1}};
    localparam logic [LEN_W-1:0]   LEN_MAX   = {LEN_W{1'b1}};
    localparam logic [CFG_W-1:0]   GRAM_CHARS_RESET = 6'd3;

    typedef logic [OFF_W-1:0]   offset_t;
    typedef logic [RING_AW-1:0] ring_ptr_t;

    // Number of continuation bytes that a lead byte announces.
    function automatic logic [LEFT_W-1:0] lead_extra(input logic [7:0] b);
        logic [LEFT_W-1:0] extra;
        begin
            extra = 2'd0;
            if ((b & 8'hE0) == 8'hC0)
            begin
                extra = 2'd1;
            end
            else if ((b & 8'hF0) == 8'hE0)
            begin
                extra = 2'd2;
            end
            else if ((b & 8'hF8) == 8'hF0)
            begin
                extra = 2'd3;
            end
            return extra;
        end
    endfunction

endpackage

// ===== rtl/core/ucng_if.sv =====
// Handshake channel interfaces of the UTF-8 character n-gram splitter.
`timescale 1ns / 1ps

interface ucng_text_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_string;

    modport source (output valid, output data_byte, output end_of_string, input ready);
    modport sink   (input valid, input data_byte, input end_of_string, output ready);
endinterface

interface ucng_gram_if;
    logic                        valid;
    logic                        ready;
    logic [ucng_pkg::OFF_W-1:0]  gram_start;
    logic [ucng_pkg::LEN_W-1:0]  gram_bytes;
    logic [ucng_pkg::IDX_W-1:0]  gram_index;
    logic                        final_gram;
    logic                        overflow;

    modport source (output valid, output gram_start, output gram_bytes, output gram_index,
                    output final_gram, output overflow, input ready);
    modport sink   (input valid, input gram_start, input gram_bytes, input gram_index,
                    input final_gram, input overflow, output ready);
endinterface

interface ucng_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [ucng_pkg::CFG_W-1:0]  gram_chars;

    modport source (output valid, output gram_chars, input ready);
    modport sink   (input valid, input gram_chars, output ready);
endinterface

// ===== rtl/core/utf8_char_ngram_splitter_unit.sv =====
// Top level of the UTF-8 character n-gram splitter.
`timescale 1ns / 1ps

// Channel  Role    Word
// -------  ------  ----------------------------------------------------------
// text     sink    data_byte, end_of_string: one byte of the string
// grams    source  gram_start, gram_bytes, gram_index, final_gram, overflow
// cfg      sink    gram_chars: characters per gram, always ready
//
// One byte is taken per cycle while text.ready is high; each byte's gram, if any, appears
// in the result register in the cycle after the byte is taken. The path is a ring-index
// subtraction, a ring read and a length subtraction. A waiting result does not stop the
// next byte while the consumer takes it in the same cycle; text.ready falls only while a
// result sits unread and grams.ready is low. Reset clears all per-string state; the ring
// of character starts is not cleared and is written before it is read.

module utf8_char_ngram_splitter_unit
(
    input  logic                 clk,
    input  logic                 rst_n,
    ucng_text_if.sink            text,
    ucng_gram_if.source          grams,
    ucng_cfg_if.sink             cfg
);

    // Ring of the byte offsets of the most recent character starts.
    ucng_pkg::offset_t   ring [ucng_pkg::MAX_GRAM_CHARS];

    logic [ucng_pkg::CFG_W-1:0]   gram_chars_reg;
    ucng_pkg::ring_ptr_t          head_reg, head_next;
    logic [ucng_pkg::POS_W-1:0]   pos_reg, pos_next;
    logic [ucng_pkg::CHARS_W-1:0] chars_reg, chars_next;
    logic [ucng_pkg::LEFT_W-1:0]  left_reg, left_next;
    logic [ucng_pkg::IDX_W-1:0]   grams_reg, grams_next;
    logic                         empty_reg, empty_next;
    logic                         ovf_reg, ovf_next;

    // Result register.
    logic                         out_vld_reg, out_vld_next;
    ucng_pkg::offset_t            out_start_reg, out_start_next;
    logic [ucng_pkg::LEN_W-1:0]   out_len_reg, out_len_next;
    logic [ucng_pkg::IDX_W-1:0]   out_idx_reg, out_idx_next;
    logic                         out_final_reg, out_final_next;
    logic                         out_ovf_reg, out_ovf_next;

    logic                         accept;
    logic                         last;
    logic [ucng_pkg::CFG_W-1:0]   n_eff;
    logic                         empty_now;
    logic                         at_cap;
    ucng_pkg::offset_t            off;
    logic                         lead;
    logic [ucng_pkg::LEFT_W-1:0]  extra;
    logic                         complete;
    logic [ucng_pkg::CHARS_W-1:0] chars_inc;
    ucng_pkg::ring_ptr_t          rd_idx;
    ucng_pkg::offset_t            start;
    logic [ucng_pkg::OFF_W:0]     len_wide;
    logic [ucng_pkg::LEN_W-1:0]   len_sat;
    logic                         emit_full;
    logic                         emit_short;

    // A new byte may enter whenever the result register is free or being emptied.
    assign text.ready  = !out_vld_reg || grams.ready;
    assign accept      = text.valid && text.ready;
    assign last        = text.end_of_string;
    assign cfg.ready   = 1'b1;

    assign grams.valid      = out_vld_reg;
    assign grams.gram_start = out_start_reg;
    assign grams.gram_bytes = out_len_reg;
    assign grams.gram_index = out_idx_reg;
    assign grams.final_gram = out_final_reg;
    assign grams.overflow   = out_ovf_reg;

    always_comb
    begin
        // Out-of-range gram sizes are clamped to the usable range.
        if (gram_chars_reg == '0)
        begin
            n_eff = ucng_pkg::CFG_W'(1);
        end
        else if (gram_chars_reg > ucng_pkg::CFG_W'(ucng_pkg::MAX_GRAM_CHARS))
        begin
            n_eff = ucng_pkg::CFG_W'(ucng_pkg::MAX_GRAM_CHARS);
        end
        else
        begin
            n_eff = gram_chars_reg;
        end

        // A string that opens with a zero byte is skipped up to its last byte.
        empty_now = empty_reg || (pos_reg == '0 && text.data_byte == 8'h00);

        // Past the byte cap every byte takes the last offset.
        at_cap = (pos_reg >= ucng_pkg::POS_W'(ucng_pkg::POS_CAP));
        off    = at_cap ? ucng_pkg::offset_t'(ucng_pkg::POS_CAP - 1)
                        : pos_reg[ucng_pkg::OFF_W-1:0];

        lead  = (left_reg == '0);
        extra = lead ? ucng_pkg::lead_extra(text.data_byte) : left_reg - 2'd1;
        // The final byte always closes the current character.
        complete = (extra == '0) || last;

        head_next = lead ? head_reg + 1'b1 : head_reg;
        chars_inc = (chars_reg == ucng_pkg::CHARS_MAX) ? chars_reg : chars_reg + 1'b1;

        // Start of the oldest character in the gram. With one-character grams and a lead
        // byte, that start is the offset being written this cycle.
        rd_idx = head_next - n_eff[ucng_pkg::RING_AW-1:0];
        start  = (lead && rd_idx == head_reg) ? off : ring[rd_idx];

        len_wide = {1'b0, off} + 17'd1 - {1'b0, start};
        len_sat  = (len_wide > 17'(ucng_pkg::LEN_MAX)) ? ucng_pkg::LEN_MAX
                                                        : len_wide[ucng_pkg::LEN_W-1:0];

        emit_full  = complete && (chars_inc >= ucng_pkg::CHARS_W'(n_eff));
        emit_short = complete && !emit_full && last;

        // Default: hold state but for the advanced ring head, drain the result register if it was taken.
        head_next  = head_next;
        pos_next   = pos_reg;
        chars_next = chars_reg;
        left_next  = left_reg;
        grams_next = grams_reg;
        empty_next = empty_reg;
        ovf_next   = ovf_reg;

        out_vld_next   = out_vld_reg && !grams.ready;
        out_start_next = out_start_reg;
        out_len_next   = out_len_reg;
        out_idx_next   = out_idx_reg;
        out_final_next = out_final_reg;
        out_ovf_next   = out_ovf_reg;

        if (!accept)
        begin
            head_next = head_reg;
        end
        else if (empty_now)
        begin
            head_next  = head_reg;
            empty_next = !last;
        end
        else
        begin
            ovf_next  = ovf_reg || at_cap;
            pos_next  = at_cap ? pos_reg : pos_reg + 1'b1;
            left_next = last ? '0 : extra;
            if (complete)
            begin
                chars_next = chars_inc;
            end

            if (emit_full)
            begin
                out_vld_next   = 1'b1;
                out_start_next = start;
                out_len_next   = len_sat;
                out_idx_next   = grams_reg;
                out_final_next = last;
                out_ovf_next   = ovf_reg || at_cap;
                grams_next     = (grams_reg == ucng_pkg::GRAMS_MAX) ? grams_reg
                                                                    : grams_reg + 1'b1;
            end
            else if (emit_short)
            begin
                // A string shorter than one gram gives a single gram over all of it.
                out_vld_next   = 1'b1;
                out_start_next = '0;
                out_len_next   = (off >= ucng_pkg::offset_t'(ucng_pkg::LEN_MAX))
                                 ? ucng_pkg::LEN_MAX
                                 : ucng_pkg::LEN_W'(off + 1'b1);
                out_idx_next   = '0;
                out_final_next = 1'b1;
                out_ovf_next   = ovf_reg || at_cap;
            end

            if (last)
            begin
                pos_next   = '0;
                chars_next = '0;
                left_next  = '0;
                grams_next = '0;
                empty_next = 1'b0;
                ovf_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gram_chars_reg <= ucng_pkg::GRAM_CHARS_RESET;
            head_reg       <= '0;
            pos_reg        <= '0;
            chars_reg      <= '0;
            left_reg       <= '0;
            grams_reg      <= '0;
            empty_reg      <= 1'b0;
            ovf_reg        <= 1'b0;
            out_vld_reg    <= 1'b0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                gram_chars_reg <= cfg.gram_chars;
            end
            head_reg    <= head_next;
            pos_reg     <= pos_next;
            chars_reg   <= chars_next;
            left_reg    <= left_next;
            grams_reg   <= grams_next;
            empty_reg   <= empty_next;
            ovf_reg     <= ovf_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Result payload and the ring carry no reset.
    always_ff @(posedge clk)
    begin
        out_start_reg <= out_start_next;
        out_len_reg   <= out_len_next;
        out_idx_reg   <= out_idx_next;
        out_final_reg <= out_final_next;
        out_ovf_reg   <= out_ovf_next;
        if (accept && !empty_now && lead)
        begin
            ring[head_reg] <= off;
        end
    end

    // The last byte of a string leaves every per-string counter at zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last) |=> (pos_reg == '0 && chars_reg == '0 && grams_reg == '0
                              && left_reg == '0 && !empty_reg && !ovf_reg))
        else $error("per-string state not cleared after the last byte");

    // Continuation bytes can only be pending inside a string that has bytes.
    assert property (@(posedge clk) disable iff (!rst_n)
        (left_reg != '0) |-> (pos_reg != '0 && !empty_reg))
        else $error("continuation count pending outside a string");

    // The overflow flag is only set once the position counter sits at the cap.
    assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> (pos_reg == ucng_pkg::POS_W'(ucng_pkg::POS_CAP)))
        else $error("overflow flag set below the byte cap");

    // A skipped empty string never produces a gram.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && empty_now && !(out_vld_reg && !grams.ready)) |=> !out_vld_reg)
        else $error("gram emitted for an empty string");

endmodule
